FILE: rtl/core/tsfo_pkg.sv
// Package for the touch sample queue with orientation stage.
// Holds beat types, register indexes and shared widths; no dependencies.
package tsfo_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned WAIT_W          = 6;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [COORD_W-1:0] WIDTH_RST  = 16'd320;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 16'd240;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] sample_x;
    logic [COORD_W-1:0] sample_y;
    logic               pressed;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               out_pressed;
    logic               from_queue;
    logic [WAIT_W-1:0]  still_waiting;
  } out_item_t;

  // One queue entry: press bit and raw point.
  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  // Raw point handed from the queue to the orientation stage on a read.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pressed;
    logic               from_queue;
    logic [WAIT_W-1:0]  remaining;
  } pop_t;

  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic               mirror_x;
    logic               mirror_y;
    logic               swap_xy;
  } orient_cfg_t;

endpackage

FILE: rtl/core/tsfo_queue.sv
// Drop-oldest sample queue with last-known point and touched flag.
// Depends on tsfo_pkg; storage is a memory with registered read and write bypass.
module tsfo_queue #(
  parameter int unsigned QUEUE_DEPTH = tsfo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  tsfo_pkg::in_item_t item,
  output tsfo_pkg::pop_t     pop
);
  import tsfo_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [COORD_W-1:0] lk_x_r, lk_x_nxt;
  logic [COORD_W-1:0] lk_y_r, lk_y_nxt;
  logic               touched_r, touched_nxt;
  entry_t             rd_data_r;
  entry_t             byp_data_r;
  logic               byp_r, byp_nxt;
  entry_t             head;
  entry_t             wr_data;
  logic [PTR_W-1:0]   wr_addr;
  logic [PTR_W:0]     slot_sum;
  logic [PTR_W-1:0]   rd_ptr_inc;
  logic               do_push, do_pop, full, empty;

  assign do_push = accept && (item.operation == OP_PUSH);
  assign do_pop  = accept && (item.operation == OP_READ);
  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign head    = byp_r ? byp_data_r : rd_data_r;

  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  // Tail slot: sum stays below twice the depth, so one compare and subtract.
  assign slot_sum = {1'b0, rd_ptr_r} + (PTR_W+1)'(count_r);
  always_comb begin
    if (full) begin
      wr_addr = rd_ptr_r;
    end else if (slot_sum >= DEPTH_X) begin
      wr_addr = PTR_W'(slot_sum - DEPTH_X);
    end else begin
      wr_addr = slot_sum[PTR_W-1:0];
    end
  end

  always_comb begin
    wr_data.pressed = item.pressed;
    wr_data.x       = item.pressed ? item.sample_x : lk_x_r;
    wr_data.y       = item.pressed ? item.sample_y : lk_y_r;
  end

  always_comb begin
    rd_ptr_nxt  = rd_ptr_r;
    count_nxt   = count_r;
    lk_x_nxt    = lk_x_r;
    lk_y_nxt    = lk_y_r;
    touched_nxt = touched_r;
    if (do_push) begin
      touched_nxt = item.pressed;
      if (item.pressed) begin
        lk_x_nxt = item.sample_x;
        lk_y_nxt = item.sample_y;
      end
      // drop the oldest entry when full; count stays at the depth
      if (full) begin
        rd_ptr_nxt = rd_ptr_inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (do_pop && !empty) begin
      rd_ptr_nxt = rd_ptr_inc;
      count_nxt  = count_r - 1'b1;
    end
  end

  assign byp_nxt = do_push && (wr_addr == rd_ptr_nxt);

  always_comb begin
    pop.valid = do_pop;
    if (empty) begin
      pop.x          = lk_x_r;
      pop.y          = lk_y_r;
      pop.pressed    = touched_r;
      pop.from_queue = 1'b0;
    end else begin
      pop.x          = head.x;
      pop.y          = head.y;
      pop.pressed    = head.pressed;
      pop.from_queue = 1'b1;
    end
    pop.remaining = WAIT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= mem[rd_ptr_nxt];
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      count_r   <= '0;
      lk_x_r    <= '0;
      lk_y_r    <= '0;
      touched_r <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
      lk_x_r    <= lk_x_nxt;
      lk_y_r    <= lk_y_nxt;
      touched_r <= touched_nxt;
      byp_r     <= byp_nxt;
    end
  end

endmodule

FILE: rtl/core/tsfo_orient.sv
// Orientation stage: bound check against previous output, mirror, swap.
// Depends on tsfo_pkg; drives the registered result beat.
module tsfo_orient (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tsfo_pkg::orient_cfg_t cfg,
  input  tsfo_pkg::pop_t        pop,
  output logic                  out_valid,
  output tsfo_pkg::out_item_t   out_item
);
  import tsfo_pkg::*;

  logic [COORD_W-1:0] prev_x_r, prev_x_nxt;
  logic [COORD_W-1:0] prev_y_r, prev_y_nxt;
  logic [COORD_W-1:0] bx, by, mx, my;
  logic               out_valid_r;
  out_item_t          out_item_r, out_item_nxt;

  // Replace an out-of-range coordinate with the last one output.
  assign bx = (pop.x >= cfg.width)  ? prev_x_r : pop.x;
  assign by = (pop.y >= cfg.height) ? prev_y_r : pop.y;
  assign mx = cfg.mirror_x ? (cfg.width  - bx - 1'b1) : bx;
  assign my = cfg.mirror_y ? (cfg.height - by - 1'b1) : by;

  always_comb begin
    out_item_nxt.out_x         = cfg.swap_xy ? my : mx;
    out_item_nxt.out_y         = cfg.swap_xy ? mx : my;
    out_item_nxt.out_pressed   = pop.pressed;
    out_item_nxt.from_queue    = pop.from_queue;
    out_item_nxt.still_waiting = pop.remaining;
    prev_x_nxt = pop.valid ? out_item_nxt.out_x : prev_x_r;
    prev_y_nxt = pop.valid ? out_item_nxt.out_y : prev_y_r;
  end

  always_ff @(posedge clk) begin
    if (pop.valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      out_valid_r <= pop.valid;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/core/touch_sample_fifo_orient_top.sv
// Top level of the touch sample queue with orientation stage.
// Depends on tsfo_pkg, tsfo_queue and tsfo_orient; holds the config registers.
//
//   channel  ports                          direction  beat marker
//   input    start, busy, in_item           in         start && !busy
//   result   out_valid, out_item            out        out_valid (one cycle)
//   config   cfg_we, cfg_index, cfg_wdata   in         cfg_we
//
// One item is taken every cycle; busy stays low. A read beat shows its result
// on out_valid the cycle after it is taken; a push beat gives no result.
// The queue memory has a registered read port with a bypass for a write to
// the head slot, so a read may follow a push directly. Synchronous reset
// empties the queue; the memory contents are not cleared.
module touch_sample_fifo_orient_top #(
  parameter int unsigned QUEUE_DEPTH = tsfo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tsfo_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  output tsfo_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [tsfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tsfo_pkg::*;

  logic [COORD_W-1:0] width_r, height_r;
  logic [2:0]         orient_r;
  orient_cfg_t        cfg;
  pop_t               pop;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      orient_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PANEL_WIDTH:  width_r  <= cfg_wdata[COORD_W-1:0];
        REG_PANEL_HEIGHT: height_r <= cfg_wdata[COORD_W-1:0];
        REG_ORIENTATION:  orient_r <= cfg_wdata[2:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    cfg.width    = width_r;
    cfg.height   = height_r;
    cfg.mirror_x = orient_r[0];
    cfg.mirror_y = orient_r[1];
    cfg.swap_xy  = orient_r[2];
  end

  tsfo_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .pop    (pop)
  );

  tsfo_orient u_orient (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/tb_touch_sample_fifo_orient_top.sv
// Testbench for touch_sample_fifo_orient_top: directed table, then random push/read traffic.
// Reads are checked against pinned values or an in-bench predictor of queue and orientation.
// Depends on tsfo_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_touch_sample_fifo_orient_top;
  import tsfo_pkg::*;

  localparam int QDEPTH        = QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int RAND_ITEMS    = 1232;
  localparam int PHASE_LEN     = 154;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic               do_cfg;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [2:0]         o;
    in_item_t           beat;
    logic               pinned;
    out_item_t          want;
  } dir_row_t;

  localparam out_item_t NO_RES = '0;
  localparam int DIR_COUNT = 21;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 1'b0, 1'b0, 6'd0}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_PUSH, 16'd319, 16'd239, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd319, 16'd239, 1'b1, 1'b1, 6'd0}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_PUSH, 16'd320, 16'd240, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd319, 16'd239, 1'b1, 1'b1, 6'd0}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd319, 16'd239, 1'b0, 1'b1, 6'd0}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
      '{16'd319, 16'd239, 1'b0, 1'b0, 6'd0}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_PUSH, 16'd0, 16'd0, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 1'b1, 1'b1, 6'd1}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 1'b1, 1'b1, 6'd0}},
    // zero bounds: every coordinate is replaced, mirroring wraps
    '{1'b1, 16'd0, 16'd0, 3'd7, '{OP_PUSH, 16'd5, 16'd6, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 6'd0}},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, 1'b1, 1'b0, 6'd0}},
    '{1'b1, 16'hFFFF, 16'hFFFF, 3'd1, '{OP_PUSH, 16'hFFFE, 16'd1, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd0, 16'd1, 1'b1, 1'b1, 6'd0}},
    '{1'b1, 16'd100, 16'd50, 3'd4, '{OP_PUSH, 16'd10, 16'd20, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd20, 16'd10, 1'b1, 1'b1, 6'd0}},
    '{1'b1, 16'd100, 16'd50, 3'd2, '{OP_PUSH, 16'd10, 16'd20, 1'b1}, 1'b0, NO_RES},
    '{1'b0, 16'd0, 16'd0, 3'd0, '{OP_READ, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{16'd10, 16'd29, 1'b1, 1'b1, 6'd0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_beat = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PANEL_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // typed expectation that travels with the current beat
  logic                  pin_valid = 1'b0;
  out_item_t             pin_value = '0;

  // predictor state
  entry_t             ring [QDEPTH];
  int                 ring_head;
  int                 ring_fill;
  logic [COORD_W-1:0] last_x, last_y, prev_x, prev_y;
  logic               touched;
  logic [COORD_W-1:0] pan_w, pan_h;
  logic [2:0]         orient;

  out_item_t pending_reads [$];
  int        mismatch_count = 0;

  touch_sample_fifo_orient_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_beat),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void clear_model();
    ring_head = 0;
    ring_fill = 0;
    last_x    = '0;
    last_y    = '0;
    prev_x    = '0;
    prev_y    = '0;
    touched   = 1'b0;
    pan_w     = WIDTH_RST;
    pan_h     = HEIGHT_RST;
    orient    = '0;
  endfunction

  function automatic void queue_sample(input in_item_t b);
    entry_t e;
    if (b.pressed) begin
      last_x  = b.sample_x;
      last_y  = b.sample_y;
      touched = 1'b1;
      e = '{pressed: 1'b1, x: b.sample_x, y: b.sample_y};
    end else begin
      touched = 1'b0;
      e = '{pressed: 1'b0, x: last_x, y: last_y};
    end
    // full: drop the oldest entry
    if (ring_fill >= QDEPTH) begin
      ring_head = (ring_head + 1) % QDEPTH;
      ring_fill = QDEPTH - 1;
    end
    ring[(ring_head + ring_fill) % QDEPTH] = e;
    ring_fill++;
  endfunction

  function automatic out_item_t orient_read();
    logic [COORD_W-1:0] x, y, t;
    logic               p, fq;
    if (ring_fill > 0) begin
      x  = ring[ring_head].x;
      y  = ring[ring_head].y;
      p  = ring[ring_head].pressed;
      ring_head = (ring_head + 1) % QDEPTH;
      ring_fill--;
      fq = 1'b1;
    end else begin
      x  = last_x;
      y  = last_y;
      p  = touched;
      fq = 1'b0;
    end
    if (x >= pan_w) x = prev_x;
    if (y >= pan_h) y = prev_y;
    if (orient[0]) x = pan_w - x - 16'd1;
    if (orient[1]) y = pan_h - y - 16'd1;
    if (orient[2]) begin
      t = x;
      x = y;
      y = t;
    end
    prev_x = x;
    prev_y = y;
    return '{out_x: x, out_y: y, out_pressed: p, from_queue: fq,
             still_waiting: WAIT_W'(ring_fill)};
  endfunction

  // check results, track config writes, predict accepted beats
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      clear_model();
      pending_reads.delete();
    end else begin
      if (out_valid) begin
        if (pending_reads.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'(out_item.out_x), 32'd0);
        end else begin
          want = pending_reads.pop_front();
          if (out_item.out_x !== want.out_x)
            flag_mismatch("out_x", 32'(out_item.out_x), 32'(want.out_x));
          if (out_item.out_y !== want.out_y)
            flag_mismatch("out_y", 32'(out_item.out_y), 32'(want.out_y));
          if (out_item.out_pressed !== want.out_pressed)
            flag_mismatch("out_pressed", 32'(out_item.out_pressed),
                          32'(want.out_pressed));
          if (out_item.from_queue !== want.from_queue)
            flag_mismatch("from_queue", 32'(out_item.from_queue),
                          32'(want.from_queue));
          if (out_item.still_waiting !== want.still_waiting)
            flag_mismatch("still_waiting", 32'(out_item.still_waiting),
                          32'(want.still_waiting));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PANEL_WIDTH:  pan_w  = cfg_wdata;
          REG_PANEL_HEIGHT: pan_h  = cfg_wdata;
          REG_ORIENTATION:  orient = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_beat.operation == OP_READ) begin
          got = orient_read();
          pending_reads.push_back(pin_valid ? pin_value : got);
        end else begin
          queue_sample(in_beat);
        end
      end
    end
  end

  task automatic send_beat(input in_item_t beat, input logic pinned,
                           input out_item_t want);
    start     <= 1'b1;
    in_beat   <= beat;
    pin_valid <= pinned;
    pin_value <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // an idle gap before about a fifth of the beats, when allowed
  task automatic idle_gap(input bit allow);
    if (allow && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // hold off until every read has returned and the pipe is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_panel(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                           input logic [2:0] o);
    cfg_beat(REG_PANEL_WIDTH, w);
    cfg_beat(REG_PANEL_HEIGHT, h);
    cfg_beat(REG_ORIENTATION, {13'($urandom), o});
    // index past the register list must be ignored
    cfg_beat(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t           beat;
    logic [COORD_W-1:0] w, h;
    int                 push_pct;
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].do_cfg) begin
        settle();
        set_panel(DIR_ROWS[i].w, DIR_ROWS[i].h, DIR_ROWS[i].o);
      end else begin
        idle_gap(1'b1);
      end
      send_beat(DIR_ROWS[i].beat, DIR_ROWS[i].pinned, DIR_ROWS[i].want);
    end

    w = WIDTH_RST;
    h = HEIGHT_RST;
    push_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        settle();
        case (n / PHASE_LEN)
          0: begin w = WIDTH_RST; h = HEIGHT_RST; end
          1: begin w = 16'd1; h = 16'd1; end
          2: begin w = 16'hFFFF; h = 16'hFFFF; end
          3: begin w = 16'($urandom_range(1, 65535)); h = 16'($urandom_range(1, 65535)); end
          4: begin w = 16'($urandom_range(1, 40)); h = 16'($urandom_range(1, 40)); end
          default: begin
            w = 16'($urandom_range(1, 800));
            h = 16'($urandom_range(1, 600));
          end
        endcase
        set_panel(w, h, 3'(n / PHASE_LEN));
      end
      // alternate fill, drain and balanced stretches so the queue overflows and empties
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      beat.operation = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_READ;
      beat.sample_x  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, int'(w)));
      beat.sample_y  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, int'(h)));
      beat.pressed   = ($urandom_range(0, 3) != 0);
      idle_gap(!(n >= 300 && n < 600));
      send_beat(beat, 1'b0, NO_RES);
    end

    settle();
    if (pending_reads.size() != 0)
      flag_mismatch("results never came", 32'(pending_reads.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
